FILE: rtl/hgn_pkg.sv
// Package with the shared types, constants and constant tables of the Gaussian noise source.
package hgn_pkg;

   localparam logic [31:0] MIX_K1   = 32'h7feb352d;
   localparam logic [31:0] MIX_K2   = 32'h846ca68b;
   localparam logic [31:0] X_OFS    = 32'h9e3779b9;
   localparam logic [31:0] Y_OFS    = 32'h85ebca6b;
   localparam logic [31:0] ST_MUL   = 32'hc2b2ae35;
   localparam logic [31:0] KEY2_XOR = 32'h68bc21eb;

   localparam logic [29:0] S_FLOOR  = 30'd540833544;
   localparam logic [31:0] LN2_Q32  = 32'hB17217F8;
   localparam logic [28:0] LOG_TOP  = 29'd419430400;
   localparam logic [31:0] PI4_LO   = 32'h0FDAA221;
   localparam logic [7:0]  PI4_HI   = 8'hC9;
   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

   localparam int LOG_ROUNDS   = 24;
   localparam int SQRT_BITS    = 27;
   localparam int RAD_STAGES   = 1 + LOG_ROUNDS + 1 + SQRT_BITS;
   localparam int HORNER_TERMS = 5;
   localparam int TRIG_CORE    = 4 + 2 * HORNER_TERMS + 1;
   localparam int TRIG_PAD     = RAD_STAGES - TRIG_CORE;

   typedef struct packed {
      logic [23:0] m1;
      logic [23:0] m2;
   } uniform_type;

   typedef struct packed {
      logic        neg;
      logic [32:0] mag;
   } cosine_type;

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'b0, a} * {32'b0, b};
      return p[31:0];
   endfunction

   function automatic logic [31:0] xs16(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

   function automatic logic [31:0] xs15(input logic [31:0] v);
      return v ^ (v >> 15);
   endfunction

   // Reciprocals ceil(2^(32+l)/k) with l = ceil(log2 k) for the series divisors.
   function automatic logic [32:0] recip(input logic use_sin, input logic [2:0] step);
      logic [32:0] r;
      case (step)
         3'd0: r = use_sin ? 33'd4997780127 : 33'd6108397933;
         3'd1: r = use_sin ? 33'd7635497416 : 33'd4908534053;
         3'd2: r = use_sin ? 33'd6544712071 : 33'd4581298450;
         3'd3: r = use_sin ? 33'd6871947674 : 33'd5726623062;
         3'd4: r = use_sin ? 33'd5726623062 : 33'd4294967296;
         default: r = 33'd4294967296;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] recip_shift(input logic use_sin, input logic [2:0] step);
      logic [5:0] s;
      case (step)
         3'd0: s = use_sin ? 6'd39 : 6'd39;
         3'd1: s = use_sin ? 6'd39 : 6'd38;
         3'd2: s = use_sin ? 6'd38 : 6'd37;
         3'd3: s = use_sin ? 6'd37 : 6'd36;
         3'd4: s = use_sin ? 6'd35 : 6'd33;
         default: s = 6'd33;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/hgn_hash.sv
// Pipelined coordinate hash that turns a pixel word into two 24-bit uniform codes.
module hgn_hash (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_in,
   input  logic [15:0]         x_coord,
   input  logic [15:0]         y_coord,
   input  logic [3:0]          stage_index,
   input  logic [1:0]          channel_index,
   input  logic [31:0]         seed,
   output logic                valid_out,
   output hgn_pkg::uniform_type uni_out
);
   import hgn_pkg::*;

   localparam int HASH_STAGES = 6;

   logic [HASH_STAGES-1:0] vld_ff;
   logic [31:0] w0_ff [3];
   logic [31:0] w0_in [3];
   logic [31:0] a1_ff [3];
   logic [31:0] a1_in [3];
   logic [31:0] a2_ff [3];
   logic [31:0] a2_in [3];
   logic [31:0] b3_ff [2];
   logic [31:0] b3_in [2];
   logic [31:0] b4_ff [2];
   logic [31:0] b4_in [2];
   uniform_type uni_ff;
   uniform_type uni_in;

   always_comb begin
      logic [31:0] key;
      logic [31:0] h0;
      logic [31:0] h1;
      w0_in[0] = {16'b0, x_coord} + X_OFS;
      w0_in[1] = {16'b0, y_coord} + Y_OFS;
      w0_in[2] = mul32({28'b0, stage_index}, ST_MUL) + {30'b0, channel_index};
      for (int l = 0; l < 3; l++) begin
         a1_in[l] = mul32(xs16(w0_ff[l]), MIX_K1);
         a2_in[l] = mul32(xs15(a1_ff[l]), MIX_K2);
      end
      key = seed ^ xs16(a2_ff[0]) ^ xs16(a2_ff[1]) ^ xs16(a2_ff[2]);
      b3_in[0] = mul32(xs16(key), MIX_K1);
      b3_in[1] = mul32(xs16(key ^ KEY2_XOR), MIX_K1);
      for (int l = 0; l < 2; l++) begin
         b4_in[l] = mul32(xs15(b3_ff[l]), MIX_K2);
      end
      h0 = xs16(b4_ff[0]);
      h1 = xs16(b4_ff[1]);
      uni_in.m1 = h0[23:0];
      uni_in.m2 = h1[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[HASH_STAGES-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff  <= w0_in;
         a1_ff  <= a1_in;
         a2_ff  <= a2_in;
         b3_ff  <= b3_in;
         b4_ff  <= b4_in;
         uni_ff <= uni_in;
      end
   end

   assign valid_out = vld_ff[HASH_STAGES-1];
   assign uni_out   = uni_ff;

endmodule

FILE: rtl/hgn_radius.sv
// Pipelined radius unit: log2 by repeated squaring, scaling to -2 ln u, then a bit-per-stage square root.
module hgn_radius (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        valid_in,
   input  logic [23:0] m1_in,
   output logic        valid_out,
   output logic [26:0] root_out
);
   import hgn_pkg::*;

   logic [RAD_STAGES-1:0] vld_ff;

   logic [31:0] f_ff     [LOG_ROUNDS+1];
   logic [31:0] f_in     [LOG_ROUNDS+1];
   logic [23:0] frac_ff  [LOG_ROUNDS+1];
   logic [23:0] frac_in  [LOG_ROUNDS+1];
   logic [4:0]  exp_ff   [LOG_ROUNDS+1];
   logic [4:0]  exp_in;
   logic        floor_ff [LOG_ROUNDS+1];
   logic        floor_in;

   logic [29:0] s_ff;
   logic [29:0] s_in;

   logic [53:0] rem_ff  [SQRT_BITS];
   logic [53:0] rem_in  [SQRT_BITS];
   logic [26:0] root_ff [SQRT_BITS];
   logic [26:0] root_in [SQRT_BITS];

   always_comb begin
      logic [24:0] v;
      logic [63:0] sq;
      logic [32:0] g;
      v = {m1_in, 1'b1};
      exp_in = '0;
      for (int b = 0; b < 25; b++) begin
         if (v[b]) begin
            exp_in = 5'(b);
         end
      end
      f_in[0]    = {7'b0, v} << (5'd31 - exp_in);
      frac_in[0] = '0;
      floor_in   = (m1_in[23:1] == 23'd0);
      for (int k = 1; k <= LOG_ROUNDS; k++) begin
         sq = {32'b0, f_ff[k-1]} * {32'b0, f_ff[k-1]};
         g  = sq[63:31];
         f_in[k]    = g[32] ? g[32:1] : g[31:0];
         frac_in[k] = {frac_ff[k-1][LOG_ROUNDS-2:0], g[32]};
      end
   end

   always_comb begin
      logic [28:0] lg;
      logic [28:0] lv;
      logic [60:0] prod;
      lg   = {exp_ff[LOG_ROUNDS], frac_ff[LOG_ROUNDS]};
      lv   = LOG_TOP - lg;
      prod = {32'b0, lv} * {29'b0, LN2_Q32};
      s_in = floor_ff[LOG_ROUNDS] ? S_FLOOR : prod[60:31];
   end

   always_comb begin
      logic [53:0] rem_src;
      logic [26:0] root_src;
      logic [55:0] trial;
      for (int b = 0; b < SQRT_BITS; b++) begin
         if (b == 0) begin
            rem_src  = {s_ff, 24'b0};
            root_src = '0;
         end else begin
            rem_src  = rem_ff[b-1];
            root_src = root_ff[b-1];
         end
         trial = (56'(root_src) << (SQRT_BITS - b)) | (56'(1) << (2 * (SQRT_BITS - 1 - b)));
         if ({2'b0, rem_src} >= trial) begin
            rem_in[b]  = 54'({2'b0, rem_src} - trial);
            root_in[b] = root_src | (27'(1) << (SQRT_BITS - 1 - b));
         end else begin
            rem_in[b]  = rem_src;
            root_in[b] = root_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RAD_STAGES-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff     <= f_in;
         frac_ff  <= frac_in;
         exp_ff[0]   <= exp_in;
         floor_ff[0] <= floor_in;
         for (int k = 1; k <= LOG_ROUNDS; k++) begin
            exp_ff[k]   <= exp_ff[k-1];
            floor_ff[k] <= floor_ff[k-1];
         end
         s_ff    <= s_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign valid_out = vld_ff[RAD_STAGES-1];
   assign root_out  = root_ff[SQRT_BITS-1];

endmodule

FILE: rtl/hgn_trig.sv
// Pipelined cosine of the phase code by octant folding and a Horner series, aligned to the radius unit.
module hgn_trig (
   input  logic               clock,
   input  logic               en,
   input  logic [23:0]        m2_in,
   output hgn_pkg::cosine_type cos_out
);
   import hgn_pkg::*;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] x2;
      logic        use_sin;
      logic        neg;
   } ctx_type;

   logic [23:0] dly_ff [TRIG_PAD];

   logic [21:0] r1_ff;
   logic [21:0] r1_in;
   logic        sin1_ff;
   logic        neg1_ff;
   logic [53:0] plo_ff;
   logic [29:0] phi_ff;
   logic        sin2_ff;
   logic        neg2_ff;
   logic [31:0] x3_ff;
   logic [31:0] x3_in;
   logic        sin3_ff;
   logic        neg3_ff;
   ctx_type     ctx4_ff;
   ctx_type     ctx4_in;

   logic [31:0] q_ff     [HORNER_TERMS];
   logic [31:0] q_in     [HORNER_TERMS];
   ctx_type     ctxa_ff  [HORNER_TERMS];
   ctx_type     ctxa_in  [HORNER_TERMS];
   logic [31:0] quot_ff  [HORNER_TERMS];
   logic [31:0] quot_in  [HORNER_TERMS];
   ctx_type     ctxb_ff  [HORNER_TERMS];

   cosine_type  cos_ff;
   cosine_type  cos_in;

   logic [24:0] p;
   logic [2:0]  oct;

   assign p   = {dly_ff[TRIG_PAD-1], 1'b1};
   assign oct = p[24:22];

   always_comb begin
      logic [22:0] mirror;
      logic [61:0] sum;
      logic [63:0] xx;
      mirror = 23'h400000 - {1'b0, p[21:0]};
      r1_in  = oct[0] ? mirror[21:0] : p[21:0];
      sum    = {phi_ff, 32'b0} + {8'b0, plo_ff};
      x3_in  = sum[61:30];
      xx     = {32'b0, x3_ff} * {32'b0, x3_ff};
      ctx4_in.x       = x3_ff;
      ctx4_in.x2      = xx[63:32];
      ctx4_in.use_sin = sin3_ff;
      ctx4_in.neg     = neg3_ff;
   end

   always_comb begin
      ctx_type     src;
      logic [32:0] t;
      logic [63:0] p1;
      logic [64:0] p2;
      for (int j = 0; j < HORNER_TERMS; j++) begin
         if (j == 0) begin
            src = ctx4_ff;
            t   = ONE_Q32;
         end else begin
            src = ctxb_ff[j-1];
            t   = ONE_Q32 - {1'b0, quot_ff[j-1]};
         end
         p1         = {31'b0, t} * {32'b0, src.x2};
         q_in[j]    = p1[63:32];
         ctxa_in[j] = src;
         p2 = {33'b0, q_ff[j]} * {32'b0, recip(ctxa_ff[j].use_sin, 3'(j))};
         quot_in[j] = 32'(p2 >> recip_shift(ctxa_ff[j].use_sin, 3'(j)));
      end
   end

   always_comb begin
      logic [32:0] t;
      logic [63:0] p3;
      t  = ONE_Q32 - {1'b0, quot_ff[HORNER_TERMS-1]};
      p3 = {32'b0, ctxb_ff[HORNER_TERMS-1].x} * {31'b0, t};
      cos_in.mag = ctxb_ff[HORNER_TERMS-1].use_sin ? {1'b0, p3[63:32]} : t;
      cos_in.neg = ctxb_ff[HORNER_TERMS-1].neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= m2_in;
         for (int i = 1; i < TRIG_PAD; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
         r1_ff   <= r1_in;
         sin1_ff <= oct[0] ^ oct[1];
         neg1_ff <= oct[1] ^ oct[2];
         plo_ff  <= {32'b0, r1_ff} * {22'b0, PI4_LO};
         phi_ff  <= {8'b0, r1_ff} * {22'b0, PI4_HI};
         sin2_ff <= sin1_ff;
         neg2_ff <= neg1_ff;
         x3_ff   <= x3_in;
         sin3_ff <= sin2_ff;
         neg3_ff <= neg2_ff;
         ctx4_ff <= ctx4_in;
         q_ff    <= q_in;
         ctxa_ff <= ctxa_in;
         quot_ff <= quot_in;
         ctxb_ff <= ctxa_ff;
         cos_ff  <= cos_in;
      end
   end

   assign cos_out = cos_ff;

endmodule

FILE: rtl/hashed_gaussian_noise.sv
// Top level of the hashed Gaussian noise source: seed register, hash, radius and cosine units, output.
// A request word passes the hash, the radius and cosine units, the product register and the output register.
// Throughput: one word per clock; every stage holds one word and the whole pipeline advances
// together whenever the output register is empty or its word is being taken.
// Reset clears the seed and all valid bits; there is no clearing pass.
module hashed_gaussian_noise (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_x_coord,
   input  logic [15:0] req_y_coord,
   input  logic [3:0]  req_stage_index,
   input  logic [1:0]  req_channel_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_gaussian_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import hgn_pkg::*;

   logic        en;
   logic [31:0] seed_ff;
   logic        hash_valid;
   uniform_type uni;
   logic        rad_valid;
   logic [26:0] root;
   cosine_type  cosv;

   logic        prod_vld_ff;
   logic [59:0] prod_ff;
   logic        prod_neg_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff;
   logic [15:0] rsp_value_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   hgn_hash u_hash (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .valid_in      (req_valid),
      .x_coord       (req_x_coord),
      .y_coord       (req_y_coord),
      .stage_index   (req_stage_index),
      .channel_index (req_channel_index),
      .seed          (seed_ff),
      .valid_out     (hash_valid),
      .uni_out       (uni)
   );

   hgn_radius u_radius (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (hash_valid),
      .m1_in     (uni.m1),
      .valid_out (rad_valid),
      .root_out  (root)
   );

   hgn_trig u_trig (
      .clock   (clock),
      .en      (en),
      .m2_in   (uni.m2),
      .cos_out (cosv)
   );

   always_comb begin
      logic [60:0] rnd;
      logic [15:0] mag;
      rnd = {1'b0, prod_ff} + (61'(1) << 43);
      mag = rnd[59:44];
      rsp_value_in = prod_neg_ff ? 16'(~mag + 16'd1) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         prod_vld_ff  <= rad_valid;
         rsp_valid_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff      <= {33'b0, root} * {27'b0, cosv.mag};
         prod_neg_ff  <= cosv.neg;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gaussian_value = rsp_value_ff;

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("Request accepted while the response word is stalled.");

   a_value_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gaussian_value <= 16'sd23300 && rsp_gaussian_value >= -16'sd23300))
      else $error("Response word exceeds the largest possible magnitude.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !prod_vld_ff))
      else $error("Valid bits not cleared by reset.");
`endif

endmodule

FILE: test/hashed_gaussian_noise_tb.sv
// Testbench for the hashed Gaussian noise source: directed and random pixels checked against a predictor.
module hashed_gaussian_noise_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 61;
   localparam int COS_K[5] = '{90, 56, 30, 12, 2};
   localparam int SIN_K[5] = '{110, 72, 42, 20, 6};

   class noise_scoreboard;
      logic [31:0] seed;
      logic [15:0] pending[$];
      int errors;
      int checked;

      function new();
         seed = '0;
         errors = 0;
         checked = 0;
      endfunction

      function logic [31:0] avalanche(input logic [31:0] v);
         logic [63:0] p;
         v = v ^ (v >> 16);
         p = {32'b0, v} * 64'h7feb352d;
         v = p[31:0];
         v = v ^ (v >> 15);
         p = {32'b0, v} * 64'h846ca68b;
         v = p[31:0];
         return v ^ (v >> 16);
      endfunction

      function logic [63:0] root64(input logic [63:0] n);
         logic [63:0] res;
         logic [63:0] b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function logic [63:0] minus_two_ln(input logic [23:0] m1);
         logic [31:0] v;
         logic [127:0] f;
         logic [63:0] lg;
         int e;
         if (m1 < 2) return 64'd540833544;
         v = 32'({m1, 1'b1});
         e = 0;
         for (int i = 0; i < 25; i++) if (v[i]) e = i;
         f = 128'(v) << (31 - e);
         lg = 64'(e) << 24;
         for (int i = 0; i < 24; i++) begin
            f = (f * f) >> 31;
            lg = lg << 1;
            if (f >= 128'h1_0000_0000) begin
               lg[0] = 1'b1;
               f = f >> 1;
            end
         end
         lg = (64'(e) << 24) | (lg & 64'hFFFFFF);
         return 64'((128'((64'd25 << 24) - lg) * 128'hB17217F8) >> 31);
      endfunction

      function logic [63:0] turn_cos(input logic [23:0] m2, output logic neg);
         logic [24:0] p;
         logic [2:0] o;
         logic [127:0] r, x, x2, t;
         logic sn;
         p = {m2, 1'b1};
         o = p[24:22];
         r = 128'(p[21:0]);
         sn = (o == 1 || o == 2 || o == 5 || o == 6);
         if (o[0]) r = 128'h400000 - r;
         x = (r * 128'hC90FDAA221) >> 30;
         x2 = (x * x) >> 32;
         neg = (o >= 2 && o <= 5);
         t = 128'h1_0000_0000;
         if (sn) begin
            foreach (SIN_K[k]) t = 128'h1_0000_0000 - ((x2 * t) >> 32) / SIN_K[k];
            return 64'((x * t) >> 32);
         end
         foreach (COS_K[k]) t = 128'h1_0000_0000 - ((x2 * t) >> 32) / COS_K[k];
         return 64'(t);
      endfunction

      function void note_pixel(input logic [15:0] x, input logic [15:0] y,
                               input logic [3:0] st, input logic [1:0] ch);
         logic [31:0] key, m;
         logic [63:0] p, s, rad, c;
         logic [127:0] mag;
         logic neg;
         p = 64'(st) * 64'hc2b2ae35;
         key = seed ^ avalanche(32'(x) + 32'h9e3779b9) ^ avalanche(32'(y) + 32'h85ebca6b)
               ^ avalanche(p[31:0] + 32'(ch));
         m = avalanche(key);
         s = minus_two_ln(m[23:0]);
         rad = root64(s << 24);
         m = avalanche(key ^ 32'h68bc21eb);
         c = turn_cos(m[23:0], neg);
         mag = (128'(rad) * 128'(c) + (128'd1 << 43)) >> 44;
         pending = {pending, ((neg && mag != 0) ? 16'(17'h10000 - mag[16:0]) : mag[15:0])};
      endfunction

      function void check_sample(input logic [15:0] got);
         logic [15:0] exp_v;
         if (pending.size() == 0) begin
            $error("unexpected word gaussian_value=%0d", $signed(got));
            errors++;
            return;
         end
         exp_v = pending.pop_front();
         checked++;
         if (exp_v !== got) begin
            $error("gaussian_value expected %0d actual %0d", $signed(exp_v), $signed(got));
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [15:0] req_x_coord = 0;
   logic [15:0] req_y_coord = 0;
   logic [3:0] req_stage_index = 0;
   logic [1:0] req_channel_index = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_gaussian_value;
   logic csr_wr_en = 0;
   logic [31:0] csr_wr_data = 0;

   noise_scoreboard sb = new();
   int stall_mode = 0;
   int sent = 0;

   always #4 clock = ~clock;

   hashed_gaussian_noise u_top (.*);

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_pixel(req_x_coord, req_y_coord, req_stage_index, req_channel_index);
      if (!reset && rsp_valid && rsp_ready) sb.check_sample(rsp_gaussian_value);
   end

   // Receiver: stall patterns chosen by stall_mode; mode 2 is a long hold-off.
   initial begin
      int cnt;
      @(negedge clock);
      forever begin
         if (stall_mode == 2) begin
            rsp_ready <= 0;
            cnt = 0;
            while (cnt < 200) begin
               @(negedge clock);
               cnt++;
            end
            stall_mode = 1;
         end else if (stall_mode == 0) begin
            rsp_ready <= 1;
            @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
            @(negedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
                             input logic [3:0] st, input logic [1:0] ch);
      req_valid <= 1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_stage_index <= st;
      req_channel_index <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      sb.seed = v;
   endtask

   task automatic random_burst(input int count);
      int n;
      n = 0;
      while (n < count) begin
         repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 3) == 0)
               send_pixel(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
            else
               send_pixel(16'($urandom), 16'($urandom), 4'($urandom), 2'($urandom));
            n++;
         end
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) pause_sender();
      end
   endtask

   initial begin
      logic [31:0] seeds[4];
      seeds = '{32'h0, 32'hFFFFFFFF, 32'h12345678, 32'h80000001};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_pixel(16'h0, 16'h0, 4'h0, 2'h0);
      send_pixel(16'hFFFF, 16'hFFFF, 4'hF, 2'h3);
      send_pixel(16'hFFFF, 16'h0, 4'h0, 2'h3);
      send_pixel(16'h0, 16'hFFFF, 4'hF, 2'h0);
      for (int i = 0; i < 16; i++) send_pixel(16'(i), 16'(15 - i), 4'(i), 2'(i));
      drain();
      foreach (seeds[s]) begin
         write_seed(seeds[s]);
         stall_mode = (s == 0) ? 0 : 1;
         if (s == 2) stall_mode = 2;
         random_burst(300);
         drain();
      end
      write_seed($urandom);
      random_burst(100);
      drain();
      repeat (LATENCY + 10) @(negedge clock);
      $display("Ran %0d pixels over five seed settings, %0d samples compared.",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

FILE: sim.f
rtl/hgn_pkg.sv
rtl/hgn_hash.sv
rtl/hgn_radius.sv
rtl/hgn_trig.sv
rtl/hashed_gaussian_noise.sv
test/hashed_gaussian_noise_tb.sv
